>>> src/keypad_scan_debounce_cursor_macros.svh
// assertion macros for the keypad scanner checker
`ifndef KEYPAD_SCAN_DEBOUNCE_CURSOR_MACROS_SVH
`define KEYPAD_SCAN_DEBOUNCE_CURSOR_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define KPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define KPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/kpd_pkg.sv
// shared constants, types and key table for the keypad scanner
`timescale 1ns / 1ps

package kpd_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_LINE_LEN = 2'd1;
    localparam logic [1:0] REG_LINE_CNT = 2'd2;

    localparam logic [15:0] DEBOUNCE_RST = 16'd50;
    localparam logic [4:0]  LINE_LEN_RST = 5'd12;
    localparam logic [2:0]  LINE_CNT_RST = 3'd2;
    localparam logic [4:0]  LINE_LEN_MAX = 5'd16;
    localparam logic [2:0]  LINE_CNT_MAX = 3'd4;
    localparam logic [3:0]  CUR_COL_RST  = 4'd2;
    localparam logic [1:0]  CUR_ROW_RST  = 2'd1;

    typedef logic [2:0] t_col_code;
    typedef logic [6:0] t_char;

    // rows top to bottom, columns 1 to 4
    localparam t_char KEY_TABLE [4][4] = '{
        '{7'h31, 7'h32, 7'h33, 7'h41},
        '{7'h34, 7'h35, 7'h36, 7'h42},
        '{7'h37, 7'h38, 7'h39, 7'h43},
        '{7'h46, 7'h30, 7'h45, 7'h44}
    };

    function automatic t_char key_lookup(logic [1:0] row, logic [1:0] col);
        return KEY_TABLE[row][col];
    endfunction

endpackage

>>> src/kpd_scan_if.sv
// scan word channel: four column encoder readings and a timestamp
`timescale 1ns / 1ps

interface kpd_scan_if;
    logic                 valid;
    logic                 ready;
    kpd_pkg::t_col_code   col1_lines;
    kpd_pkg::t_col_code   col2_lines;
    kpd_pkg::t_col_code   col3_lines;
    kpd_pkg::t_col_code   col4_lines;
    logic [31:0]          now_ms;

    modport source (output valid, col1_lines, col2_lines, col3_lines, col4_lines, now_ms,
                    input ready);
    modport sink   (input valid, col1_lines, col2_lines, col3_lines, col4_lines, now_ms,
                    output ready);
endinterface

>>> src/kpd_key_if.sv
// key result channel: held and accepted flags, character and cursor position
`timescale 1ns / 1ps

interface kpd_key_if;
    logic             valid;
    logic             ready;
    logic             key_held;
    logic             key_accepted;
    kpd_pkg::t_char   key_char;
    logic [3:0]       write_col;
    logic [1:0]       write_row;
    logic             display_cleared;

    modport source (output valid, key_held, key_accepted, key_char, write_col, write_row,
                    display_cleared, input ready);
    modport sink   (input valid, key_held, key_accepted, key_char, write_col, write_row,
                    display_cleared, output ready);
endinterface

>>> src/keypad_scan_debounce_cursor.sv
// keypad scanner top level: key decode, debounce and display cursor
`timescale 1ns / 1ps

// Takes one keypad scan word per clock when not stalled and returns one key word per
// scan, held first in the scan register, then passed through the decode, debounce
// and cursor logic into the result register. Back-to-back scans are handled because
// the debounce time, key-down flag and cursor update in the same cycle the result is
// registered, so the next scan sees them at once. The sustained rate is one scan per
// clock while the result side keeps taking words. Registers sit on an APB port at
// 0x0 debounce_ms, 0x4 line_length, 0x8 line_count and should be written while idle.

module keypad_scan_debounce_cursor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    kpd_scan_if.sink                    i_scan,
    kpd_key_if.source                   o_key,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kpd_pkg::ADDR_W-1:0]  paddr,
    input  logic [kpd_pkg::DATA_W-1:0]  pwdata,
    output logic [kpd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    // configuration
    logic [15:0] r_debounce;
    logic [4:0]  r_line_len;
    logic [2:0]  r_line_cnt;

    // scan register
    logic                 r_in_valid;
    kpd_pkg::t_col_code   r_col1, r_col2, r_col3, r_col4;
    logic [31:0]          r_now;

    // block state
    logic [31:0] r_last_time;
    logic        r_key_down;
    logic [3:0]  r_cur_col;
    logic [1:0]  r_cur_row;

    // result register
    logic            r_out_valid;
    logic            r_held;
    logic            r_accepted;
    kpd_pkg::t_char  r_char;
    logic [3:0]      r_wcol;
    logic [1:0]      r_wrow;
    logic            r_cleared;

    logic                cfg_wr;
    logic                out_load;
    logic                held;
    kpd_pkg::t_col_code  sel_code;
    logic [1:0]          sel_col;
    kpd_pkg::t_char      key_ch;
    logic [31:0]         elapsed;
    logic                accept;
    logic [4:0]          len_eff;
    logic [2:0]          cnt_eff;
    logic [4:0]          col_inc;
    logic [2:0]          row_inc;
    logic                line_wrap;
    logic                last_line;
    logic [3:0]          n_cur_col;
    logic [1:0]          n_cur_row;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            kpd_pkg::REG_DEBOUNCE: prdata = {16'd0, r_debounce};
            kpd_pkg::REG_LINE_LEN: prdata = {27'd0, r_line_len};
            kpd_pkg::REG_LINE_CNT: prdata = {29'd0, r_line_cnt};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= kpd_pkg::DEBOUNCE_RST;
            r_line_len <= kpd_pkg::LINE_LEN_RST;
            r_line_cnt <= kpd_pkg::LINE_CNT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                kpd_pkg::REG_DEBOUNCE: r_debounce <= pwdata[15:0];
                kpd_pkg::REG_LINE_LEN: r_line_len <= pwdata[4:0];
                kpd_pkg::REG_LINE_CNT: r_line_cnt <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_load     = r_in_valid && (!r_out_valid || o_key.ready);
    assign i_scan.ready = !r_in_valid || out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_scan.ready) begin
            r_in_valid <= i_scan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.valid && i_scan.ready) begin
            r_col1 <= i_scan.col1_lines;
            r_col2 <= i_scan.col2_lines;
            r_col3 <= i_scan.col3_lines;
            r_col4 <= i_scan.col4_lines;
            r_now  <= i_scan.now_ms;
        end
    end

    // ---------------- decode ----------------
    // first column whose bit 0 is low wins
    always_comb begin
        held     = 1'b1;
        sel_code = r_col4;
        sel_col  = 2'd3;
        priority if (!r_col1[0]) begin
            sel_code = r_col1;
            sel_col  = 2'd0;
        end else if (!r_col2[0]) begin
            sel_code = r_col2;
            sel_col  = 2'd1;
        end else if (!r_col3[0]) begin
            sel_code = r_col3;
            sel_col  = 2'd2;
        end else if (!r_col4[0]) begin
            sel_code = r_col4;
            sel_col  = 2'd3;
        end else begin
            held = 1'b0;
        end
    end

    assign key_ch = kpd_pkg::key_lookup(sel_code[2:1], sel_col);

    // wrapping difference against the last accepted press
    assign elapsed = r_now - r_last_time;
    assign accept  = held && !r_key_down && (elapsed >= {16'd0, r_debounce});

    // ---------------- cursor ----------------
    assign len_eff   = (r_line_len > kpd_pkg::LINE_LEN_MAX) ? kpd_pkg::LINE_LEN_MAX : r_line_len;
    assign cnt_eff   = (r_line_cnt > kpd_pkg::LINE_CNT_MAX) ? kpd_pkg::LINE_CNT_MAX : r_line_cnt;
    assign col_inc   = {1'b0, r_cur_col} + 5'd1;
    assign row_inc   = {1'b0, r_cur_row} + 3'd1;
    assign line_wrap = col_inc >= len_eff;
    assign last_line = row_inc >= cnt_eff;
    assign n_cur_col = line_wrap ? 4'd0 : col_inc[3:0];
    assign n_cur_row = !line_wrap ? r_cur_row : (last_line ? 2'd0 : row_inc[1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_key_down  <= 1'b0;
            r_cur_col   <= kpd_pkg::CUR_COL_RST;
            r_cur_row   <= kpd_pkg::CUR_ROW_RST;
        end else if (out_load) begin
            if (!held) begin
                r_key_down <= 1'b0;
            end else if (accept) begin
                r_key_down  <= 1'b1;
                r_last_time <= r_now;
                r_cur_col   <= n_cur_col;
                r_cur_row   <= n_cur_row;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_key.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_held     <= held;
            r_accepted <= accept;
            r_char     <= accept ? key_ch : '0;
            r_wcol     <= accept ? r_cur_col : '0;
            r_wrow     <= accept ? r_cur_row : '0;
            r_cleared  <= accept && line_wrap && last_line;
        end
    end

    assign o_key.valid           = r_out_valid;
    assign o_key.key_held        = r_held;
    assign o_key.key_accepted    = r_accepted;
    assign o_key.key_char        = r_char;
    assign o_key.write_col       = r_wcol;
    assign o_key.write_row       = r_wrow;
    assign o_key.display_cleared = r_cleared;

endmodule

>>> src/kpd_checker.sv
// port checker for the keypad scanner, bound to the top level
`timescale 1ns / 1ps
`include "keypad_scan_debounce_cursor_macros.svh"

module kpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_key_held,
    input logic        i_key_accepted,
    input logic [6:0]  i_key_char,
    input logic [3:0]  i_write_col,
    input logic [1:0]  i_write_row,
    input logic        i_display_cleared
);

    logic [15:0] key_word;
    logic        stall;
    logic        out_acc;
    logic        out_idle;
    logic        write_zero;

    assign key_word   = {i_key_held, i_key_accepted, i_key_char, i_write_col, i_write_row,
                         i_display_cleared};
    assign stall      = i_out_valid && !i_out_ready;
    assign out_acc    = i_out_valid && i_key_accepted;
    assign out_idle   = i_out_valid && !i_key_accepted;
    assign write_zero = (i_key_char == 7'd0) && (i_write_col == 4'd0) && (i_write_row == 2'd0)
                        && !i_display_cleared;

    // a stalled word keeps its contents
    `KPD_ASSERT_NEXT(a_out_hold, stall, i_out_valid && $stable(key_word), "stalled word changed")

    // acceptance needs a key in the scan
    `KPD_ASSERT_NOW(a_accept_held, out_acc, i_key_held, "key accepted without a held key")

    // no acceptance means an all-zero write
    `KPD_ASSERT_NOW(a_idle_zero, out_idle, write_zero, "write fields set without acceptance")

    // every table entry is printable
    `KPD_ASSERT_NOW(a_char_set, out_acc, i_key_char != 7'd0, "accepted key with empty character")

endmodule

bind keypad_scan_debounce_cursor kpd_checker u_kpd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_key.valid),
    .i_out_ready       (o_key.ready),
    .i_key_held        (o_key.key_held),
    .i_key_accepted    (o_key.key_accepted),
    .i_key_char        (o_key.key_char),
    .i_write_col       (o_key.write_col),
    .i_write_row       (o_key.write_row),
    .i_display_cleared (o_key.display_cleared)
);
